/* rtl/dpb_pkg.sv */
package dpb_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  localparam int unsigned CFG_SIZE_W  = 11;
  localparam int unsigned INV_W       = 24;
  localparam int unsigned DEPTH_W     = 16;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned COORD_W     = 32;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned FRAC_SHIFT  = 16;

  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_SIZE_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [INV_W-1:0]      RST_INV_FOCAL    = 24'd31957;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_INV_FOCAL    = 2'd2
  } cfg_index_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_DEPTH,
    S_MUL_INV,
    S_ROUND,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_depth;
    logic mul_inv;
    logic round;
    logic finish;
  } dpb_cmd_t;

  typedef struct packed {
    logic out_free;
  } dpb_sts_t;

endpackage

/* rtl/dpb_if.sv */
interface dpb_in_if;
  import dpb_pkg::*;

  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth_mm;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;

  modport source (output valid, output depth_mm, output red, output green, output blue,
                  input ready);
  modport sink (input valid, input depth_mm, input red, input green, input blue,
                output ready);
endinterface

interface dpb_out_if;
  import dpb_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [DEPTH_W-1:0] x_mm;
  logic signed [COORD_W-1:0] y_pos;
  logic signed [COORD_W-1:0] z_pos;
  logic        [COLOR_W-1:0] red_out;
  logic        [COLOR_W-1:0] green_out;
  logic        [COLOR_W-1:0] blue_out;
  logic                      last_of_frame;

  modport source (output valid, output x_mm, output y_pos, output z_pos, output red_out,
                  output green_out, output blue_out, output last_of_frame, input ready);
  modport sink (input valid, input x_mm, input y_pos, input z_pos, input red_out,
                input green_out, input blue_out, input last_of_frame, output ready);
endinterface

/* rtl/dpb_ctrl.sv */
module dpb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dpb_pkg::dpb_sts_t sts_i,
  output dpb_pkg::dpb_cmd_t cmd_o
);
  import dpb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) state_d = S_MUL_DEPTH;
      S_MUL_DEPTH: state_d = S_MUL_INV;
      S_MUL_INV:   state_d = S_ROUND;
      S_ROUND:     state_d = S_FINISH;
      S_FINISH:    if (sts_i.out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_MUL_DEPTH: cmd_o.mul_depth = 1'b1;
      S_MUL_INV:   cmd_o.mul_inv = 1'b1;
      S_ROUND:     cmd_o.round = 1'b1;
      S_FINISH:    cmd_o.finish = sts_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_MUL_DEPTH)
    else $error("accepted pixel did not start the multiply sequence");

  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && !sts_i.out_free) |=> state_q == S_FINISH)
    else $error("sequence left finish while output register was busy");

  a_finish_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> state_q == S_IDLE)
    else $error("sequence did not return to idle after the output load");
`endif

endmodule

/* rtl/dpb_datapath.sv */
module dpb_datapath #(
  parameter int unsigned MAX_WIDTH  = dpb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = dpb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [dpb_pkg::CFG_INDEX_W-1:0]          cfg_index_i,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]           cfg_data_i,
  input  logic [dpb_pkg::DEPTH_W-1:0]              depth_mm_i,
  input  logic [dpb_pkg::COLOR_W-1:0]              red_i,
  input  logic [dpb_pkg::COLOR_W-1:0]              green_i,
  input  logic [dpb_pkg::COLOR_W-1:0]              blue_i,
  input  dpb_pkg::dpb_cmd_t                        cmd_i,
  output dpb_pkg::dpb_sts_t                        sts_o,
  dpb_out_if.source                                pt_o
);
  import dpb_pkg::*;

  localparam int unsigned CW_X  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW_Y  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned LW_X  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LW_Y  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LW_XY = (LW_X > LW_Y) ? LW_X : LW_Y;
  localparam int unsigned UW    = (LW_XY > CFG_SIZE_W) ? LW_XY : CFG_SIZE_W;
  localparam int unsigned PW1   = UW + DEPTH_W;
  localparam int unsigned PW    = PW1 + INV_W;
  localparam int unsigned QW    = PW - FRAC_SHIFT + 1;

  localparam logic [QW-1:0] POS_LIM = QW'(64'h7FFF_FFFF);
  localparam logic [QW-1:0] NEG_LIM = QW'(64'h8000_0000);
  localparam logic [PW:0]   RND_BIAS = (PW+1)'((64'd1 << FRAC_SHIFT) - 64'd1);

  // configuration registers
  logic [CFG_SIZE_W-1:0] frame_width_q, frame_height_q;
  logic [INV_W-1:0]      inv_focal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      inv_focal_q    <= RST_INV_FOCAL;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q <= cfg_data_i[CFG_SIZE_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[CFG_SIZE_W-1:0];
        CFG_INV_FOCAL:    inv_focal_q <= cfg_data_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size, center and position counters
  logic [UW-1:0]   w_used, h_used, cx, cy;
  logic [CW_X-1:0] col_q, col_d;
  logic [CW_Y-1:0] row_q, row_d;
  logic [UW:0]     row_inc, col_inc;
  logic            row_end, col_end, last_d;

  always_comb begin
    if (frame_width_q == '0) begin
      w_used = UW'(1);
    end else if (UW'(frame_width_q) > UW'(MAX_WIDTH)) begin
      w_used = UW'(MAX_WIDTH);
    end else begin
      w_used = UW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h_used = UW'(1);
    end else if (UW'(frame_height_q) > UW'(MAX_HEIGHT)) begin
      h_used = UW'(MAX_HEIGHT);
    end else begin
      h_used = UW'(frame_height_q);
    end
    cx = w_used >> 1;
    cy = h_used >> 1;
  end

  // a counter at or past the last index counts as at the end
  assign row_inc = (UW+1)'(row_q) + (UW+1)'(1);
  assign col_inc = (UW+1)'(col_q) + (UW+1)'(1);
  assign row_end = row_inc >= (UW+1)'(h_used);
  assign col_end = col_inc >= (UW+1)'(w_used);
  assign last_d  = row_end && col_end;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.load) begin
      if (row_end) begin
        row_d = '0;
        col_d = col_end ? '0 : col_inc[CW_X-1:0];
      end else begin
        row_d = row_inc[CW_Y-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // offsets from the center as sign and magnitude
  logic signed [UW:0] off_y, off_z;
  logic [UW-1:0]      mag_y_d, mag_z_d;

  assign off_y   = $signed({1'b0, UW'(col_q)}) - $signed({1'b0, cx});
  assign off_z   = $signed({1'b0, cy}) - $signed({1'b0, UW'(row_q)});
  assign mag_y_d = off_y[UW] ? UW'(-off_y) : UW'(off_y);
  assign mag_z_d = off_z[UW] ? UW'(-off_z) : UW'(off_z);

  logic [UW-1:0]      mag_y_q, mag_z_q;
  logic               neg_y_q, neg_z_q, last_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [COLOR_W-1:0] red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_y_q <= mag_y_d;
      mag_z_q <= mag_z_d;
      neg_y_q <= off_y[UW];
      neg_z_q <= off_z[UW];
      depth_q <= depth_mm_i;
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      last_q  <= last_d;
    end
  end

  // offset times depth, then times the focal reciprocal
  logic [PW1-1:0] pd_y_q, pd_z_q;
  logic [PW-1:0]  pr_y_q, pr_z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_depth) begin
      pd_y_q <= PW1'(mag_y_q) * PW1'(depth_q);
      pd_z_q <= PW1'(mag_z_q) * PW1'(depth_q);
    end
    if (cmd_i.mul_inv) begin
      pr_y_q <= PW'(pd_y_q) * PW'(inv_focal_q);
      pr_z_q <= PW'(pd_z_q) * PW'(inv_focal_q);
    end
  end

  // scale down, rounding the magnitude up for negative values (floor overall)
  logic [PW:0]   sum_y, sum_z;
  logic [QW-1:0] q_y_q, q_z_q;

  assign sum_y = (PW+1)'(pr_y_q) + RND_BIAS;
  assign sum_z = (PW+1)'(pr_z_q) + RND_BIAS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      q_y_q <= neg_y_q ? sum_y[PW:FRAC_SHIFT] : {1'b0, pr_y_q[PW-1:FRAC_SHIFT]};
      q_z_q <= neg_z_q ? sum_z[PW:FRAC_SHIFT] : {1'b0, pr_z_q[PW-1:FRAC_SHIFT]};
    end
  end

  function automatic logic [COORD_W-1:0] to_coord(logic [QW-1:0] q, logic neg);
    logic [COORD_W-1:0] res;
    if (neg) begin
      res = (q > NEG_LIM) ? COORD_W'(NEG_LIM) : COORD_W'(0) - q[COORD_W-1:0];
    end else begin
      res = (q > POS_LIM) ? COORD_W'(POS_LIM) : q[COORD_W-1:0];
    end
    return res;
  endfunction

  // output register
  logic                      out_valid_q, out_valid_d;
  logic        [DEPTH_W-1:0] x_mm_q;
  logic signed [COORD_W-1:0] y_pos_q, z_pos_q;
  logic        [COLOR_W-1:0] red_out_q, green_out_q, blue_out_q;
  logic                      last_out_q;

  assign sts_o.out_free = !out_valid_q || pt_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (pt_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      x_mm_q      <= depth_q;
      y_pos_q     <= $signed(to_coord(q_y_q, neg_y_q));
      z_pos_q     <= $signed(to_coord(q_z_q, neg_z_q));
      red_out_q   <= red_q;
      green_out_q <= green_q;
      blue_out_q  <= blue_q;
      last_out_q  <= last_q;
    end
  end

  assign pt_o.valid         = out_valid_q;
  assign pt_o.x_mm          = x_mm_q;
  assign pt_o.y_pos         = y_pos_q;
  assign pt_o.z_pos         = z_pos_q;
  assign pt_o.red_out       = red_out_q;
  assign pt_o.green_out     = green_out_q;
  assign pt_o.blue_out      = blue_out_q;
  assign pt_o.last_of_frame = last_out_q;

`ifndef SYNTHESIS
  a_frame_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && last_d) |=> (col_q == '0 && row_q == '0))
    else $error("position counters did not wrap at end of frame");

  a_counters_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.load |=> ($stable(col_q) && $stable(row_q)))
    else $error("position counters moved without a pixel transfer");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> (!out_valid_q || pt_o.ready))
    else $error("output register overwritten before its transfer");
`endif

endmodule

/* rtl/depth_pixel_backprojection.sv */
// Depth pixel back-projection: turns each depth pixel into a 3-D point.
// Channels: pix_i takes depth_mm plus red/green/blue of one pixel; pt_o
// gives x_mm (= depth), y_pos and z_pos (1/256 mm, saturated, floor rounding),
// the colour and last_of_frame. Both use valid/ready; a transfer happens on
// a rising edge with valid and ready high. Pixels of a frame come column by
// column with the row running fastest; internal counters track the position.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 frame_width, 1 frame_height, 2 inv_focal); write only while idle.
// The sequencer steps one pixel through depth multiply, focal multiply,
// rounding and output load, and takes no new pixel until it is back in idle.
// A finished point sits in an output register, so the next pixel is taken
// while it waits; if the receiver stalls longer, the next point holds in
// the finish step and pix_i stays not ready until the register frees.
// Reset (rst_ni low, asynchronous) clears the position counters, the output
// valid and loads 640 x 480 with inv_focal 31957.
module depth_pixel_backprojection #(
  parameter int unsigned MAX_WIDTH  = dpb_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = dpb_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dpb_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  dpb_in_if.sink                          pix_i,
  dpb_out_if.source                       pt_o
);
  import dpb_pkg::*;

  dpb_cmd_t cmd;
  dpb_sts_t sts;
  logic     in_ready;

  assign pix_i.ready = in_ready;

  dpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dpb_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .depth_mm_i  (pix_i.depth_mm),
    .red_i       (pix_i.red),
    .green_i     (pix_i.green),
    .blue_i      (pix_i.blue),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pt_o        (pt_o)
  );

endmodule

/* verif/depth_pixel_backprojection_tb.sv */
module depth_pixel_backprojection_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dpb_pkg::*;

  typedef struct {
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } pixel_t;

  typedef struct {
    logic        [DEPTH_W-1:0] x_mm;
    logic signed [COORD_W-1:0] y_pos;
    logic signed [COORD_W-1:0] z_pos;
    logic        [COLOR_W-1:0] red;
    logic        [COLOR_W-1:0] green;
    logic        [COLOR_W-1:0] blue;
    logic                      last;
  } point_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  dpb_in_if  pix_if ();
  dpb_out_if pt_if ();

  depth_pixel_backprojection u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix_if),
    .pt_o        (pt_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow of the block's registers and position counters
  logic [CFG_SIZE_W-1:0] width_reg  = RST_FRAME_WIDTH;
  logic [CFG_SIZE_W-1:0] height_reg = RST_FRAME_HEIGHT;
  logic [INV_W-1:0]      inv_reg    = RST_INV_FOCAL;
  int unsigned           col_pos    = 0;
  int unsigned           row_pos    = 0;

  pixel_t pixels_q[$];
  point_t points_q[$];
  int     pixels_sent = 0;
  int     errors = 0;

  // idle pattern state for each side
  int tx_left = 0;
  bit tx_calm = 1'b0;
  int tx_wait = 0;
  int rx_left = 0;
  bit rx_calm = 1'b0;
  int rx_wait = 0;

  // long receiver stall
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  pixel_t next_px;
  point_t want_pt;

  function automatic int unsigned used_size(logic [CFG_SIZE_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  // floor(offset * depth * inv / 2^16), saturated to 32 bits
  function automatic logic signed [COORD_W-1:0] scaled_offset(longint offset,
                                                              logic [DEPTH_W-1:0] depth,
                                                              logic [INV_W-1:0] inv);
    longint prod;
    longint q;
    prod = offset * longint'(depth) * longint'(inv);
    q = prod >>> FRAC_SHIFT;
    if (q > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (q < -64'sd2147483648) return 32'sh80000000;
    return q[COORD_W-1:0];
  endfunction

  function automatic point_t project_pixel(logic [DEPTH_W-1:0] depth, logic [COLOR_W-1:0] r,
                                           logic [COLOR_W-1:0] g, logic [COLOR_W-1:0] b);
    point_t      pt;
    int unsigned w_used;
    int unsigned h_used;
    longint      cx;
    longint      cy;
    w_used   = used_size(width_reg, DEF_MAX_WIDTH);
    h_used   = used_size(height_reg, DEF_MAX_HEIGHT);
    cx       = w_used / 2;
    cy       = h_used / 2;
    pt.x_mm  = depth;
    pt.y_pos = scaled_offset(longint'(col_pos) - cx, depth, inv_reg);
    pt.z_pos = scaled_offset(cy - longint'(row_pos), depth, inv_reg);
    pt.red   = r;
    pt.green = g;
    pt.blue  = b;
    pt.last  = 1'b0;
    // counters past a shrunken size count as being at the end
    if (row_pos + 1 >= h_used) begin
      row_pos = 0;
      if (col_pos + 1 >= w_used) begin
        col_pos = 0;
        pt.last = 1'b1;
      end else begin
        col_pos++;
      end
    end else begin
      row_pos++;
    end
    return pt;
  endfunction

  // stretches of items either with no idling or with random idling
  function automatic int draw_wait(ref int left, ref bit calm);
    if (left == 0) begin
      left = $urandom_range(10, 60);
      calm = ($urandom_range(0, 2) == 0);
    end
    left--;
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp);
    if (got !== exp)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, exp));
  endtask

  // input side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (pix_if.valid && pix_if.ready)
        points_q.insert(points_q.size(), project_pixel(pix_if.depth_mm, pix_if.red,
                                                       pix_if.green, pix_if.blue));
      if (!pix_if.valid || pix_if.ready) begin
        if (tx_wait != 0) begin
          tx_wait--;
          pix_if.valid <= 1'b0;
        end else if (pixels_q.size() != 0) begin
          next_px = pixels_q.pop_front();
          pix_if.depth_mm <= next_px.depth;
          pix_if.red      <= next_px.red;
          pix_if.green    <= next_px.green;
          pix_if.blue     <= next_px.blue;
          pix_if.valid    <= 1'b1;
          tx_wait = draw_wait(tx_left, tx_calm);
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left <= 200;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        if (points_q.size() == 0) begin
          report_mismatch("point transfer with nothing expected");
        end else begin
          want_pt = points_q.pop_front();
          check_field("x_mm", 32'(pt_if.x_mm), 32'(want_pt.x_mm));
          check_field("y_pos", pt_if.y_pos, want_pt.y_pos);
          check_field("z_pos", pt_if.z_pos, want_pt.z_pos);
          check_field("red_out", 32'(pt_if.red_out), 32'(want_pt.red));
          check_field("green_out", 32'(pt_if.green_out), 32'(want_pt.green));
          check_field("blue_out", 32'(pt_if.blue_out), 32'(want_pt.blue));
          check_field("last_of_frame", 32'(pt_if.last_of_frame), 32'(want_pt.last));
        end
        rx_wait = draw_wait(rx_left, rx_calm);
      end
      if (hold_left != 0) begin
        pt_if.ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        pt_if.ready <= 1'b0;
      end else begin
        pt_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic [DEPTH_W-1:0] rand_depth();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return DEPTH_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_SIZE_W-1:0] rand_size();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 11'd1;
      2:       return '1;
      3:       return CFG_SIZE_W'($urandom_range(1, 1024));
      default: return CFG_SIZE_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [INV_W-1:0] rand_inv();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return INV_W'($urandom_range(1, 255));
      default: return INV_W'($urandom_range(0, 24'hFFFFFF));
    endcase
  endfunction

  task automatic push_pixel(input logic [DEPTH_W-1:0] d, input logic [COLOR_W-1:0] r,
                            input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
    pixel_t px;
    px.depth = d;
    px.red   = r;
    px.green = g;
    px.blue  = b;
    pixels_q.insert(pixels_q.size(), px);
    pixels_sent++;
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = data[CFG_SIZE_W-1:0];
      CFG_FRAME_HEIGHT: height_reg = data[CFG_SIZE_W-1:0];
      CFG_INV_FOCAL:    inv_reg = data[INV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pixels_q.size() != 0 || pix_if.valid || points_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(input bit set_w, input logic [CFG_SIZE_W-1:0] w,
                           input bit set_h, input logic [CFG_SIZE_W-1:0] h,
                           input bit set_inv, input logic [INV_W-1:0] inv, input int n);
    bit wrote;
    wrote = 1'b0;
    if (set_w) begin
      write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
      wrote = 1'b1;
    end
    if (set_h) begin
      write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
      wrote = 1'b1;
    end
    if (set_inv) begin
      write_reg(CFG_INV_FOCAL, CFG_DATA_W'(inv));
      wrote = 1'b1;
    end
    if (wrote)
      @(posedge clk_i) cfg_we_i <= 1'b0;
    @(negedge clk_i);
    repeat (n)
      push_pixel(rand_depth(), COLOR_W'($urandom_range(0, 255)),
                 COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)));
    wait_drained();
  endtask

  initial begin
    pix_if.valid    = 1'b0;
    pix_if.depth_mm = '0;
    pix_if.red      = '0;
    pix_if.green    = '0;
    pix_if.blue     = '0;
    pt_if.ready     = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration, field extremes and bit patterns
    @(negedge clk_i);
    push_pixel(16'd0, 8'd0, 8'd0, 8'd0);
    push_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(16'd1, 8'd1, 8'd1, 8'd1);
    push_pixel(16'h8000, 8'h80, 8'h80, 8'h80);
    push_pixel(16'h7FFF, 8'h7F, 8'h7F, 8'h7F);
    push_pixel(16'h5555, 8'h55, 8'hAA, 8'h55);
    push_pixel(16'hAAAA, 8'hAA, 8'h55, 8'hAA);
    push_pixel(16'hFFFF, 8'h00, 8'hFF, 8'h00);
    push_pixel(16'd1000, 8'hFF, 8'h00, 8'hFF);
    push_pixel(16'd4095, 8'h12, 8'h34, 8'h56);
    wait_drained();

    // zero sizes act as 1x1 and shrink the frame mid-way; zero focal reciprocal
    run_phase(1'b1, 11'd0, 1'b1, 11'd0, 1'b1, 24'd0, 6);
    // oversized frame clamps to the maximum, offsets saturate at once
    run_phase(1'b1, 11'h7FF, 1'b1, 11'h7FF, 1'b1, 24'hFFFFFF, 30);
    // single column tall enough to saturate vertical both ways, under a long stall
    @(negedge clk_i) hold_req <= 1'b1;
    run_phase(1'b1, 11'd1, 1'b1, 11'd259, 1'b0, 24'd0, 300);
    // single row wide enough to saturate lateral both ways
    run_phase(1'b1, 11'd259, 1'b1, 11'd1, 1'b1, 24'hFFFFF0, 300);
    run_phase(1'b1, 11'd1024, 1'b1, 11'd1024, 1'b1, 24'd1, 20);

    while (pixels_sent < 1550)
      run_phase(1'($urandom_range(0, 1)), rand_size(), 1'($urandom_range(0, 1)), rand_size(),
                1'($urandom_range(0, 1)), rand_inv(), $urandom_range(10, 100));

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
rtl/dpb_pkg.sv
rtl/dpb_if.sv
rtl/dpb_ctrl.sv
rtl/dpb_datapath.sv
rtl/depth_pixel_backprojection.sv
verif/depth_pixel_backprojection_tb.sv
